>>> sv/gft_pkg.sv
// gft_pkg: shared types, codes and helpers for the gossip freshness table
// no dependencies; used by gft_front, gft_queue, gft_back and the top level
package gft_pkg;

	// default sizes handed to the top-level parameters
	localparam int NODE_COUNT_DEF = 256;
	localparam int TIME_BITS_DEF  = 32;

	// fixed field widths
	localparam int ID_W   = 8;
	localparam int HOP_W  = 8;
	localparam int SEEN_W = 8;
	localparam int TIN_W  = 32;
	localparam int OC_W   = 3;

	// stream widths
	localparam int S_TDATA_W = 112;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 4;

	// result outcome codes
	typedef enum logic [OC_W-1:0] {
		OUT_NEW   = 3'd0,
		OUT_NEWER = 3'd1,
		OUT_EQUAL = 3'd2,
		OUT_STALE = 3'd3,
		OUT_OWN   = 3'd4
	} outcome_t;

	// classification made at the front
	typedef struct packed {
		logic sender;    // sender's own record
		logic own;       // added record naming this node
		logic out_range; // node id past the table
	} cls_t;

	localparam int CLS_W = $bits(cls_t);

	// queue item width for a given time width
	function automatic int item_width(input int tbits);
		item_width = CLS_W + ID_W + HOP_W + 3 * tbits;
	endfunction

	// saturating 8-bit increment
	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		sat_inc = (v == 8'hFF) ? 8'hFF : v + 8'd1;
	endfunction

endpackage

>>> sv/gft_front.sv
// gft_front: input transaction intake, own-node register and record classification
// depends on gft_pkg
module gft_front #(
	parameter int NODE_COUNT = gft_pkg::NODE_COUNT_DEF,
	parameter int TIME_BITS  = gft_pkg::TIME_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [gft_pkg::ID_W-1:0]                  cfg_wdata,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic [gft_pkg::S_TDATA_W-1:0]             s_tdata,
	input  logic [gft_pkg::S_TUSER_W-1:0]             s_tuser,
	input  logic                                      q_full,
	input  logic                                      clearing,
	output logic                                      q_push,
	output logic [gft_pkg::item_width(TIME_BITS)-1:0] q_wdata
);
	import gft_pkg::*;

	logic [ID_W-1:0]      own_node_q;
	logic [ID_W-1:0]      node_id;
	logic [TIN_W-1:0]     origin_in, sent_in, now_in;
	logic [HOP_W-1:0]     hop_in;
	logic [TIME_BITS-1:0] t_val, sent_val, now_val;
	cls_t                 cls;

	// own node id register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_node_q <= '0;
		end else if (cfg_we) begin
			own_node_q <= cfg_wdata;
		end
	end

	// unpack the transaction
	assign node_id   = s_tdata[7:0];
	assign origin_in = s_tdata[39:8];
	assign hop_in    = s_tdata[47:40];
	assign sent_in   = s_tdata[79:48];
	assign now_in    = s_tdata[111:80];

	// times kept in the low TIME_BITS bits
	assign t_val    = TIME_BITS'(origin_in);
	assign sent_val = TIME_BITS'(sent_in);
	assign now_val  = TIME_BITS'(now_in);

	// classify
	always_comb begin
		cls.sender    = s_tuser[0];
		cls.own       = !s_tuser[0] && (node_id == own_node_q);
		cls.out_range = !(32'(node_id) < NODE_COUNT);
	end

	// handshake into the queue; no intake while the table is being cleared
	assign s_tready = !q_full && !clearing;
	assign q_push   = s_tvalid && s_tready;
	assign q_wdata  = {cls, node_id, sat_inc(hop_in), t_val, sent_val, now_val};

endmodule

>>> sv/gft_queue.sv
// gft_queue: two-entry queue between record intake and table update
// depends on gft_pkg (item_width and TIME_BITS_DEF give the default width W)
module gft_queue #(
	parameter int W = gft_pkg::item_width(gft_pkg::TIME_BITS_DEF)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         full,
	output logic         not_empty,
	output logic [W-1:0] rdata
);
	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign rdata     = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

>>> sv/gft_back.sv
// gft_back: table memory, clearing pass, read-modify-write of one entry, result register
// depends on gft_pkg
module gft_back #(
	parameter int NODE_COUNT = gft_pkg::NODE_COUNT_DEF,
	parameter int TIME_BITS  = gft_pkg::TIME_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      q_not_empty,
	input  logic [gft_pkg::item_width(TIME_BITS)-1:0] q_rdata,
	output logic                                      q_pop,
	output logic                                      clearing,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	output logic [gft_pkg::M_TDATA_W-1:0]             m_tdata,
	output logic [gft_pkg::M_TUSER_W-1:0]             m_tuser
);
	import gft_pkg::*;

	localparam int ITEM_W = item_width(TIME_BITS);
	localparam int IDX_W  = $clog2(NODE_COUNT);
	localparam int EXT_W  = (IDX_W > ID_W) ? IDX_W : ID_W;
	localparam int WORD_W = 1 + 3 * TIME_BITS + HOP_W + SEEN_W;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0]  clr_q;
	logic [WORD_W-1:0] mem [NODE_COUNT];
	logic [WORD_W-1:0] rdata_q;
	logic [ITEM_W-1:0] cur_q;

	// queue head fields
	cls_t                 h_cls;
	logic [ID_W-1:0]      h_id, h_hop1;
	logic [TIME_BITS-1:0] h_t, h_sent, h_now;
	logic [EXT_W-1:0]     h_ext;
	logic [IDX_W-1:0]     h_idx;

	// current item fields
	cls_t                 c_cls;
	logic [ID_W-1:0]      c_id, c_hop1;
	logic [TIME_BITS-1:0] c_t, c_sent, c_now;
	logic [EXT_W-1:0]     c_ext;
	logic [IDX_W-1:0]     c_idx;

	// stored entry fields
	logic                 e_valid;
	logic [TIME_BITS-1:0] e_time, e_recv, e_rebro;
	logic [HOP_W-1:0]     e_dist;
	logic [SEEN_W-1:0]    e_seen;

	// update results
	logic [TIME_BITS-1:0] n_time, n_recv, n_rebro;
	logic [HOP_W-1:0]     n_dist;
	logic [SEEN_W-1:0]    n_seen;
	outcome_t             n_oc;
	logic                 n_notify;

	logic                 out_free, bypass, load_out, mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [WORD_W-1:0]    mem_wdata;
	outcome_t             out_oc;
	logic                 out_notify;
	logic [HOP_W-1:0]     out_dist;
	logic [SEEN_W-1:0]    out_seen;

	outcome_t             oc_q;
	logic                 notify_q;
	logic [HOP_W-1:0]     dist_q;
	logic [SEEN_W-1:0]    seen_q;
	logic                 m_tvalid_q;

	assign {h_cls, h_id, h_hop1, h_t, h_sent, h_now} = q_rdata;
	assign {c_cls, c_id, c_hop1, c_t, c_sent, c_now} = cur_q;
	assign {e_valid, e_time, e_dist, e_seen, e_recv, e_rebro} = rdata_q;

	assign h_ext = EXT_W'(h_id);
	assign h_idx = h_ext[IDX_W-1:0];
	assign c_ext = EXT_W'(c_id);
	assign c_idx = c_ext[IDX_W-1:0];

	// pop when idle and the result register can take a result
	assign clearing = (state_q == ST_CLEAR);
	assign out_free = !m_tvalid_q || m_tready;
	assign q_pop    = (state_q == ST_IDLE) && q_not_empty && out_free;
	assign bypass   = h_cls.own || h_cls.out_range;

	// entry update
	always_comb begin
		n_time   = e_time;
		n_recv   = e_recv;
		n_rebro  = e_rebro;
		n_dist   = e_dist;
		n_seen   = e_seen;
		n_notify = 1'b0;
		if (!e_valid) begin
			n_oc    = OUT_NEW;
			n_time  = c_t;
			n_recv  = c_now;
			n_rebro = '0;
			n_dist  = c_cls.sender ? 8'd1 : c_hop1;
			n_seen  = c_cls.sender ? 8'd0 : 8'd1;
		end else if (c_t > e_time) begin
			n_oc     = OUT_NEWER;
			n_time   = c_t;
			n_recv   = c_now;
			n_dist   = c_hop1;
			n_seen   = 8'd1;
			n_notify = c_cls.sender;
		end else if (c_t < e_time) begin
			n_oc = OUT_STALE;
		end else begin
			n_oc = OUT_EQUAL;
			if (!c_cls.sender) begin
				n_rebro = c_sent;
				if (c_hop1 < e_dist) begin
					n_dist = c_hop1;
				end
			end
			n_seen = sat_inc(e_seen);
		end
	end

	// memory write side: clearing pass or entry update
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = c_idx;
		mem_wdata = {1'b1, n_time, n_dist, n_seen, n_recv, n_rebro};
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == ST_LOOK) begin
			mem_we = 1'b1;
		end
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[h_idx];
	end

	// current item
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_rdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(NODE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop && !bypass) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// result selection
	always_comb begin
		load_out   = (q_pop && bypass) || (state_q == ST_LOOK);
		out_oc     = n_oc;
		out_notify = n_notify;
		out_dist   = n_dist;
		out_seen   = n_seen;
		if (state_q != ST_LOOK) begin
			out_oc     = h_cls.own ? OUT_OWN : OUT_STALE;
			out_notify = 1'b0;
			out_dist   = '0;
			out_seen   = '0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			oc_q     <= out_oc;
			notify_q <= out_notify;
			dist_q   <= out_dist;
			seen_q   <= out_seen;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {seen_q, dist_q};
	assign m_tuser  = {notify_q, oc_q};

endmodule

>>> sv/gossip_freshness_table_update.sv
// gossip_freshness_table_update: top level of the per-node gossip freshness table
// depends on gft_pkg, gft_front, gft_queue, gft_back
//
// channel   direction  signals                            contents
// s_*       in         s_tvalid s_tready s_tdata s_tuser  one node record
// m_*       out        m_tvalid m_tready m_tdata m_tuser  outcome and entry state
// cfg_*     in         cfg_we cfg_wdata                   own node id
//
// a record whose entry is looked up passes through the update stage as a table
// read in ST_IDLE, then a write in ST_LOOK, set by the registered table read;
// own-node and out-of-range records skip ST_LOOK. a two-entry queue decouples intake.
// after reset a clearing pass over all NODE_COUNT entries holds s_tready low.
// a stalled m_tready holds the result register and backs up through the queue.
module gossip_freshness_table_update #(
	parameter int NODE_COUNT = gft_pkg::NODE_COUNT_DEF,
	parameter int TIME_BITS  = gft_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gft_pkg::ID_W-1:0]      cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// node_id[7:0] origin_time[39:8] hop_distance[47:40]
	// message_sent_time[79:48] now_ms[111:80]
	input  logic [gft_pkg::S_TDATA_W-1:0] s_tdata,
	// is_sender_record[0]
	input  logic [gft_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// stored_distance[7:0] seen_count[15:8]
	output logic [gft_pkg::M_TDATA_W-1:0] m_tdata,
	// outcome[2:0] notify_app[3]
	output logic [gft_pkg::M_TUSER_W-1:0] m_tuser
);
	import gft_pkg::*;

	localparam int ITEM_W = item_width(TIME_BITS);

	logic              q_full, q_push, q_pop, q_not_empty, clearing;
	logic [ITEM_W-1:0] q_wdata, q_rdata;

	// intake and classification
	gft_front #(
		.NODE_COUNT(NODE_COUNT),
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.clearing (clearing),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	// decoupling queue
	gft_queue #(
		.W(ITEM_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.pop      (q_pop),
		.full     (q_full),
		.not_empty(q_not_empty),
		.rdata    (q_rdata)
	);

	// table update and result
	gft_back #(
		.NODE_COUNT(NODE_COUNT),
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.clearing   (clearing),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule
